// ----- hdl/ndsw_pkg.sv -----
// Shared types and constants for the normal/depth similarity weight pipeline.
package ndsw_pkg;

  // Configuration register indexes
  localparam logic REG_NORMAL_TOL = 1'b0;
  localparam logic REG_DEPTH_TOL  = 1'b1;

  // Reset values of the tolerances
  localparam logic [15:0] NORMAL_TOL_RESET = 16'd2458;
  localparam logic [31:0] DEPTH_TOL_RESET  = 32'd65536;

  // Square root pipeline: 33-bit radicand, 17-bit root, one root bit per stage
  localparam int SQRT_W     = 33;
  localparam int ROOT_W     = 17;
  localparam int SQ_W       = 35;

  // Quotient widths of the two ratio dividers
  localparam int NQ_W = 32;
  localparam int DQ_W = 16;

  localparam logic [ROOT_W-1:0] SIM_MAX = 17'd32768;

  // Sideband that rides along the square root pipelines
  typedef struct packed {
    logic            cut;
    logic [DQ_W-1:0] qd;
  } side_t;

endpackage

// ----- hdl/ndsw_isqrt_pipe.sv -----
// Pipelined floor square root, one root bit resolved per register stage.
module ndsw_isqrt_pipe
  import ndsw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQRT_W-1:0] in_value,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic              vld  [0:ROOT_W];
  logic [SQRT_W-1:0] val  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  logic [SQ_W-1:0]   rsq  [0:ROOT_W];
  side_t             side [0:ROOT_W];

  assign vld[0]  = in_valid;
  assign val[0]  = in_value;
  assign root[0] = '0;
  assign rsq[0]  = '0;
  assign side[0] = in_side;

  // Stage k tries root bit ROOT_W-1-k; the square of the trial is kept incrementally
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int B = ROOT_W - 1 - k;
    logic [SQ_W-1:0] trial_sq;

    assign trial_sq = rsq[k] + (SQ_W'(root[k]) << (B + 1)) + (SQ_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val[k+1]  <= val[k];
        side[k+1] <= side[k];
        if (trial_sq <= SQ_W'(val[k])) begin
          root[k+1] <= root[k] | (ROOT_W'(1) << B);
          rsq[k+1]  <= trial_sq;
        end else begin
          root[k+1] <= root[k];
          rsq[k+1]  <= rsq[k];
        end
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

// ----- hdl/normal_depth_similarity_weight.sv -----
// Top level: edge-stopping similarity weight from two normal/depth samples.
//
// Takes one pair of G-buffer samples per cycle unless the output stalls and returns one
// Q1.15 weight per pair, via the 32-step restoring divider for the normal ratio, a
// 17-step square root on its quotient and two more in parallel for both factors; the
// depth ratio is divided in the same stages. The whole pipeline advances together and
// halts while the output item waits to be taken. The user must write tolerances via
// the cfg port (index 0 normal, 1 depth) only while idle; the block does not check it.
module normal_depth_similarity_weight
  import ndsw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_normal_x, first_normal_y, first_normal_z, first_depth,
  // second_normal_x, second_normal_y, second_normal_z, second_depth
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // similarity
  output logic [15:0]  m_axis_tdata
);

  logic [15:0] normal_tol;
  logic [31:0] depth_tol;
  logic [31:0] tt;
  logic        en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_tol <= NORMAL_TOL_RESET;
      depth_tol  <= DEPTH_TOL_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_NORMAL_TOL: normal_tol <= cfg_wdata[15:0];
        REG_DEPTH_TOL:  depth_tol  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Squared normal tolerance, refreshed every cycle
  always_ff @(posedge clk) begin
    tt <= 32'(normal_tol) * 32'(normal_tol);
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage A: component and depth differences
  logic signed [16:0] a_dx, a_dy, a_dz;
  logic [31:0]        a_dd;
  logic               a_v;
  logic [31:0]        in_d1, in_d2;

  assign in_d1 = s_axis_tdata[79:48];
  assign in_d2 = s_axis_tdata[159:128];

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= $signed({s_axis_tdata[15], s_axis_tdata[15:0]})
            - $signed({s_axis_tdata[95], s_axis_tdata[95:80]});
      a_dy <= $signed({s_axis_tdata[31], s_axis_tdata[31:16]})
            - $signed({s_axis_tdata[111], s_axis_tdata[111:96]});
      a_dz <= $signed({s_axis_tdata[47], s_axis_tdata[47:32]})
            - $signed({s_axis_tdata[127], s_axis_tdata[127:112]});
      a_dd <= (in_d1 >= in_d2) ? in_d1 - in_d2 : in_d2 - in_d1;
    end
  end

  // Stage B: squares
  logic [32:0] b_sx, b_sy, b_sz;
  logic [31:0] b_dd;
  logic        b_v;
  logic signed [33:0] sq_x, sq_y, sq_z;

  assign sq_x = a_dx * a_dx;
  assign sq_y = a_dy * a_dy;
  assign sq_z = a_dz * a_dz;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sx <= sq_x[32:0];
      b_sy <= sq_y[32:0];
      b_sz <= sq_z[32:0];
      b_dd <= a_dd;
    end
  end

  // Stage C: sum of squares and both cutoff tests
  logic [34:0] s_sum;
  logic [31:0] c_s, c_dd;
  logic        c_cut, c_v;

  assign s_sum = 35'(b_sx) + 35'(b_sy) + 35'(b_sz);

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_s   <= s_sum[31:0];
      c_dd  <= b_dd;
      c_cut <= (s_sum >= 35'(tt)) || (b_dd >= depth_tol);
    end
  end

  // Restoring dividers: S*2^32/T^2 (32 steps) and dd*2^16/dtol (first 16 steps)
  logic            dv   [0:NQ_W];
  logic            dcut [0:NQ_W];
  logic [31:0]     nrem [0:NQ_W];
  logic [NQ_W-1:0] nq   [0:NQ_W];
  logic [31:0]     drem [0:NQ_W];
  logic [DQ_W-1:0] dq   [0:NQ_W];

  assign dv[0]   = c_v;
  assign dcut[0] = c_cut;
  assign nrem[0] = c_s;
  assign nq[0]   = '0;
  assign drem[0] = c_dd;
  assign dq[0]   = '0;

  for (genvar i = 0; i < NQ_W; i++) begin : g_div
    logic [32:0] nsh, dsh;
    assign nsh = {nrem[i], 1'b0};
    assign dsh = {drem[i], 1'b0};

    always_ff @(posedge clk) begin
      if (rst) dv[i+1] <= 1'b0;
      else if (en) dv[i+1] <= dv[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dcut[i+1] <= dcut[i];
        if (nsh >= {1'b0, tt}) begin
          nrem[i+1] <= 32'(nsh - {1'b0, tt});
          nq[i+1]   <= {nq[i][NQ_W-2:0], 1'b1};
        end else begin
          nrem[i+1] <= nsh[31:0];
          nq[i+1]   <= {nq[i][NQ_W-2:0], 1'b0};
        end
      end
    end

    if (i < DQ_W) begin : g_dstep
      always_ff @(posedge clk) begin
        if (en) begin
          if (dsh >= {1'b0, depth_tol}) begin
            drem[i+1] <= 32'(dsh - {1'b0, depth_tol});
            dq[i+1]   <= {dq[i][DQ_W-2:0], 1'b1};
          end else begin
            drem[i+1] <= dsh[31:0];
            dq[i+1]   <= {dq[i][DQ_W-2:0], 1'b0};
          end
        end
      end
    end else begin : g_dhold
      always_ff @(posedge clk) begin
        if (en) begin
          drem[i+1] <= drem[i];
          dq[i+1]   <= dq[i];
        end
      end
    end
  end

  // qn = isqrt of the normal ratio
  side_t             sq1_side_in, sq1_side;
  logic              sq1_v;
  logic [ROOT_W-1:0] qn_root;

  assign sq1_side_in = '{cut: dcut[NQ_W], qd: dq[NQ_W]};

  ndsw_isqrt_pipe u_sqrt_qn (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv[NQ_W]),
    .in_value  ({1'b0, nq[NQ_W]}),
    .in_side   (sq1_side_in),
    .out_valid (sq1_v),
    .out_root  (qn_root),
    .out_side  (sq1_side)
  );

  // Stage E: radicands (1 - q) in Q1.32 for both factors
  logic [SQRT_W-1:0] e_un, e_ud;
  side_t             e_side;
  logic              e_v;
  logic [16:0]       un_hi, ud_hi;

  assign un_hi = 17'h10000 - {1'b0, qn_root[15:0]};
  assign ud_hi = 17'h10000 - {1'b0, sq1_side.qd};

  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (en) e_v <= sq1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_un   <= {un_hi, 16'b0};
      e_ud   <= {ud_hi, 16'b0};
      e_side <= sq1_side;
    end
  end

  // Square roots of both factors in parallel
  side_t             nf_side, df_side;
  logic              nf_v, df_v;
  logic [ROOT_W-1:0] nf, df;

  ndsw_isqrt_pipe u_sqrt_nf (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_v),
    .in_value  (e_un),
    .in_side   (e_side),
    .out_valid (nf_v),
    .out_root  (nf),
    .out_side  (nf_side)
  );

  ndsw_isqrt_pipe u_sqrt_df (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_v),
    .in_value  (e_ud),
    .in_side   (e_side),
    .out_valid (df_v),
    .out_root  (df),
    .out_side  (df_side)
  );

  // Stage F: product of the two factors
  logic [33:0] f_prod;
  logic        f_cut, f_v;

  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= nf_v && df_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_prod <= 34'(nf) * 34'(df);
      f_cut  <= nf_side.cut || df_side.cut;
    end
  end

  // Stage G: scale, zero on cutoff, saturate, output register
  logic [ROOT_W-1:0] w;

  assign w = f_prod[33:17];

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= f_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_cut) m_axis_tdata <= '0;
      else if (w > SIM_MAX) m_axis_tdata <= SIM_MAX[15:0];
      else m_axis_tdata <= w[15:0];
    end
  end

endmodule

// ----- sim/tb_normal_depth_similarity_weight.sv -----
// Testbench for the normal/depth similarity weight pipeline: random and directed sample pairs.
module tb_normal_depth_similarity_weight
  import ndsw_pkg::*;
();

  typedef struct packed {
    logic [31:0] d2;
    logic [15:0] n2z, n2y, n2x;
    logic [31:0] d1;
    logic [15:0] n1z, n1y, n1x;
  } pair_t;

  localparam int LATENCY = 72;
  localparam longint CYCLE_LIMIT = 400000;

  logic         clk;
  logic         rst;
  logic         cfg_wen;
  logic         cfg_addr;
  logic [31:0]  cfg_wdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;

  pair_t       pending_pairs[$];
  logic [15:0] expected_weights[$];
  logic [15:0] ntol;
  logic [31:0] dtol;
  int          errors;
  longint      cycles;
  int          send_gap;
  int          recv_gap;
  bit          hold_send;

  normal_depth_similarity_weight i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor square root of a value below 2^33
  function automatic logic [16:0] floor_sqrt(logic [32:0] v);
    logic [16:0] r;
    logic [16:0] c;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      c = r | (17'd1 << b);
      if ({17'd0, c} * {17'd0, c} <= {1'b0, v}) r = c;
    end
    return r;
  endfunction

  function automatic logic [15:0] similarity_of(pair_t p);
    longint s, tt, dd, qn, qd, c, w, a, b;
    longint nf, df;
    a = longint'($signed(p.n1x)) - longint'($signed(p.n2x));
    s = a * a;
    a = longint'($signed(p.n1y)) - longint'($signed(p.n2y));
    s += a * a;
    a = longint'($signed(p.n1z)) - longint'($signed(p.n2z));
    s += a * a;
    tt = longint'(ntol) * longint'(ntol);
    a = longint'(p.d1);
    b = longint'(p.d2);
    dd = a >= b ? a - b : b - a;
    if (s >= tt || dd >= longint'(dtol)) return 16'd0;
    qn = 0;
    for (int bit_i = 15; bit_i >= 0; bit_i--) begin
      c = qn | (longint'(1) << bit_i);
      if (unsigned'(c * c * tt) <= unsigned'(s << 32)) qn = c;
    end
    qd = (dd << 16) / longint'(dtol);
    nf = floor_sqrt(33'((65536 - qn) << 16));
    df = floor_sqrt(33'((65536 - qd) << 16));
    w = (nf * df) >> 17;
    if (w > 32768) w = 32768;
    return w[15:0];
  endfunction

  function automatic pair_t random_pair(int mode);
    pair_t p;
    p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (mode != 0) begin
      // near pairs so the weight is often nonzero
      p.n2x = p.n1x + 16'($signed($urandom_range(0, 2 * ntol)) - $signed(ntol) / 2);
      p.n2y = p.n1y + 16'($signed($urandom_range(0, ntol)) - $signed(ntol) / 2);
      p.n2z = p.n1z + 16'($signed($urandom_range(0, ntol)) - $signed(ntol) / 2);
      p.d2  = p.d1 + 32'($urandom_range(0, dtol > 2 ? dtol : 2)) - dtol / 2;
    end
    return p;
  endfunction

  task automatic write_reg(logic addr, logic [31:0] data);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (addr == REG_NORMAL_TOL) ntol = data[15:0];
    else dtol = data;
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || s_axis_tvalid || expected_weights.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] nt, logic [31:0] dt, int count);
    pair_t p;
    write_reg(REG_NORMAL_TOL, {16'd0, nt});
    write_reg(REG_DEPTH_TOL, dt);
    for (int i = 0; i < count; i++) begin
      p = random_pair($urandom_range(0, 3));
      pending_pairs.push_back(p);
    end
    wait_drained();
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
    end else begin
      if (s_axis_tvalid) begin
        expected_weights.push_back(similarity_of(pair_t'(s_axis_tdata)));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pairs.size() != 0 && !hold_send) begin
        s_axis_tdata  <= pending_pairs.pop_front();
        s_axis_tvalid <= 1'b1;
        send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin : monitor_proc
    int draw;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_weights.size() == 0) begin
          $error("similarity: unexpected item, actual %0d", m_axis_tdata);
          errors++;
        end else begin
          if (m_axis_tdata !== expected_weights[0]) begin
            $error("similarity: expected %0d actual %0d", expected_weights[0], m_axis_tdata);
            errors++;
          end
          void'(expected_weights.pop_front());
        end
        // idle cycles before the next item; zero keeps ready high
        draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
        recv_gap <= (draw > 0) ? draw - 1 : 0;
        m_axis_tready <= (draw == 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_normal_depth_similarity_weight failed");
      $finish;
    end
  end

  initial begin
    pair_t p;
    errors = 0;
    cycles = 0;
    hold_send = 1'b0;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_addr = REG_NORMAL_TOL;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    ntol = NORMAL_TOL_RESET;
    dtol = DEPTH_TOL_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: identical samples, extremes, cutoff boundaries at reset tolerances
    p = '0;
    pending_pairs.push_back(p);
    p = '{32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 32'h0,
          16'h7FFF, 16'h7FFF, 16'h7FFF};
    pending_pairs.push_back(p);
    p = '{32'h0, 16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF,
          16'h8000, 16'h7FFF, 16'h8000};
    pending_pairs.push_back(p);
    p = '0; p.n2x = 16'd2458;
    pending_pairs.push_back(p);
    p = '0; p.n2x = 16'd2457;
    pending_pairs.push_back(p);
    p = '0; p.d2 = 32'd65536;
    pending_pairs.push_back(p);
    p = '0; p.d2 = 32'd65535;
    pending_pairs.push_back(p);
    p = '0; p.d1 = 32'd65535; p.n1y = 16'hFFFF; p.n2z = 16'd1;
    pending_pairs.push_back(p);
    p = '0; p.d1 = 32'd1000; p.d2 = 32'd2000; p.n1z = 16'd16384; p.n2z = 16'd16000;
    pending_pairs.push_back(p);
    for (int i = 0; i < 12; i++) pending_pairs.push_back(random_pair(1));
    wait_drained();

    // pause the sender with items in flight until every result is back, then resume
    run_phase(NORMAL_TOL_RESET, DEPTH_TOL_RESET, 150);
    for (int i = 0; i < 20; i++) pending_pairs.push_back(random_pair(1));
    while (expected_weights.size() < 4) @(posedge clk);
    hold_send = 1'b1;
    while (expected_weights.size() != 0 || s_axis_tvalid) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();

    run_phase(16'd1, 32'd1, 100);
    run_phase(16'hFFFF, 32'hFFFF_FFFF, 200);
    run_phase(16'd300, 32'd5000, 200);
    run_phase(16'd40000, 32'd1, 100);
    run_phase(16'd1, 32'hFFFF_FFFF, 100);
    run_phase(16'($urandom_range(1, 65535)), $urandom | 32'd1, 250);

    if (errors == 0) begin
      $display("tb_normal_depth_similarity_weight passed");
    end else begin
      $display("tb_normal_depth_similarity_weight failed");
    end
    $finish;
  end

endmodule
